// ----- hdl/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Sizes, operation and status codes, controller states and the command and
// status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

   // storage geometry
   localparam int DEPTH          = 16;
   localparam int VALUE_WIDTH    = 32;
   localparam int PRIORITY_WIDTH = 16;

   // widths of the channel fields
   localparam int FUNC_W   = 2;
   localparam int IN_VAL_W = 32;
   localparam int IN_PRI_W = 16;
   localparam int STAT_W   = 2;
   localparam int POS_W    = 4;
   localparam int OCC_W    = 5;

   // internal index and counter widths
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_SEARCH = 2'd1,
      FUNC_REMOVE = 2'd2
   } func_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2
   } status_type;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;   // capture the accepted item, restart the scan
      logic step;       // advance the scan index
      logic finish;     // apply the operation and load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;       // scan has reached its answer
   } dp_stat_type;

endpackage : spq_pkg
`default_nettype wire

// ----- hdl/sorted_priority_queue_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_top: priority queue kept as a sorted list
// Up to DEPTH entries (value, priority) in ascending priority, ties in
// arrival order; insert, search by value and remove by value.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/ready): func, item_value, item_priority. One item is
//    in work at a time; req_ready is high only while the block is idle.
//  - rsp channel (valid/ready): status, position, found_priority, occupancy,
//    one result item per request item, in order.
//  - Scan: after acceptance the scan compares one stored entry per cycle,
//    up to a hit or the end of the held entries; a full insert or an
//    unknown func is answered with no scan step. The result is valid from
//    the edge that ends the last scan cycle. After each result the block
//    returns to idle before it accepts the next item, so a new item is
//    taken only once the last one has reached the output register.
//  - Stall: a waiting result sits in the output register; the block accepts
//    and scans the next item, and holds at the end of the scan until the
//    output register is taken.
//  - Reset: synchronous, active high; the queue is emptied and no result is
//    pending. Stored entries need no clearing, only held ones are read.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire         [spq_pkg::FUNC_W-1:0]    req_func,
   input  wire signed  [spq_pkg::IN_VAL_W-1:0]  req_item_value,
   input  wire signed  [spq_pkg::IN_PRI_W-1:0]  req_item_priority,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic        [spq_pkg::STAT_W-1:0]    rsp_status,
   output logic        [spq_pkg::POS_W-1:0]     rsp_position,
   output logic signed [spq_pkg::IN_PRI_W-1:0]  rsp_found_priority,
   output logic        [spq_pkg::OCC_W-1:0]     rsp_occupancy
);
   import spq_pkg::*;

   cmd_type     cmd;
   dp_stat_type dp_stat;

   // sequencing
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .dp_stat   (dp_stat)
   );

   // storage and scan
   spq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_func           (req_func),
      .req_item_value     (req_item_value),
      .req_item_priority  (req_item_priority),
      .rsp_status         (rsp_status),
      .rsp_position       (rsp_position),
      .rsp_found_priority (rsp_found_priority),
      .rsp_occupancy      (rsp_occupancy),
      .cmd                (cmd),
      .dp_stat            (dp_stat)
   );

endmodule : sorted_priority_queue_top
`default_nettype wire

// ----- hdl/spq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl: sequencing for the sorted priority queue
// Accepts one item at a time, steps the datapath scan until it reports an
// answer, then hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output spq_pkg::cmd_type     cmd,
   input  spq_pkg::dp_stat_type dp_stat
);
   import spq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // state and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!dp_stat.done) begin
               cmd.step = 1'b1;
            end else if (slot_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : spq_ctrl
`default_nettype wire

// ----- hdl/spq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath: entry storage, scan and result register
// Holds the sorted entries, compares one entry per scan step, and applies
// insert (shift toward the tail) or remove (shift toward the head).
// ----------------------------------------------------------------------------
module spq_datapath (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire         [spq_pkg::FUNC_W-1:0]    req_func,
   input  wire signed  [spq_pkg::IN_VAL_W-1:0]  req_item_value,
   input  wire signed  [spq_pkg::IN_PRI_W-1:0]  req_item_priority,
   output logic        [spq_pkg::STAT_W-1:0]    rsp_status,
   output logic        [spq_pkg::POS_W-1:0]     rsp_position,
   output logic signed [spq_pkg::IN_PRI_W-1:0]  rsp_found_priority,
   output logic        [spq_pkg::OCC_W-1:0]     rsp_occupancy,
   input  spq_pkg::cmd_type                     cmd,
   output spq_pkg::dp_stat_type                 dp_stat
);
   import spq_pkg::*;

   // entry storage
   logic        [VALUE_WIDTH-1:0]    val_ff [DEPTH];
   logic signed [PRIORITY_WIDTH-1:0] pri_ff [DEPTH];
   logic        [CNT_W-1:0]          count_ff, count_in;

   // captured item and scan index
   logic        [FUNC_W-1:0]         func_ff;
   logic        [VALUE_WIDTH-1:0]    v_ff;
   logic signed [PRIORITY_WIDTH-1:0] p_ff;
   logic        [CNT_W-1:0]          idx_ff;

   // result register
   logic        [STAT_W-1:0]         status_ff, status_in;
   logic        [POS_W-1:0]          pos_ff, pos_in;
   logic signed [IN_PRI_W-1:0]       fpri_ff, fpri_in;
   logic        [OCC_W-1:0]          occ_ff, occ_in;

   logic        [VALUE_WIDTH-1:0]    rd_val;
   logic signed [PRIORITY_WIDTH-1:0] rd_pri;
   logic                             is_ins, is_look, full, in_range, hit;
   logic                             do_ins, do_rem;

   // compare at the scan index
   assign rd_val   = val_ff[idx_ff[IDX_W-1:0]];
   assign rd_pri   = pri_ff[idx_ff[IDX_W-1:0]];
   assign is_ins   = (func_ff == FUNC_INSERT);
   assign is_look  = (func_ff == FUNC_SEARCH) || (func_ff == FUNC_REMOVE);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign in_range = (idx_ff < count_ff);
   assign hit      = in_range && (is_ins ? (p_ff < rd_pri) : (v_ff == rd_val));

   assign dp_stat.done = !(is_ins || is_look) || (is_ins && full) || !in_range || hit;

   // the insert point is the first strictly greater priority, or the tail
   assign do_ins = cmd.finish && is_ins && !full;
   assign do_rem = cmd.finish && (func_ff == FUNC_REMOVE) && hit;

   // result fields
   always_comb begin
      status_in = STAT_NOT_FOUND;
      pos_in    = '0;
      fpri_in   = '0;
      count_in  = count_ff;
      if (is_ins) begin
         if (full) begin
            status_in = STAT_FULL;
         end else begin
            status_in = STAT_OK;
            pos_in    = POS_W'(idx_ff);
            count_in  = count_ff + CNT_W'(1);
         end
      end else if (is_look && hit) begin
         status_in = STAT_OK;
         pos_in    = POS_W'(idx_ff);
         fpri_in   = IN_PRI_W'(rd_pri);
         if (func_ff == FUNC_REMOVE) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
      occ_in = OCC_W'(count_in);
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.finish) begin
         count_ff <= count_in;
      end
   end

   // item capture, scan index and result register
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         v_ff    <= VALUE_WIDTH'($unsigned(req_item_value));
         p_ff    <= PRIORITY_WIDTH'(req_item_priority);
         idx_ff  <= '0;
      end else if (cmd.step) begin
         idx_ff  <= idx_ff + CNT_W'(1);
      end
      if (cmd.finish) begin
         status_ff <= status_in;
         pos_ff    <= pos_in;
         fpri_ff   <= fpri_in;
         occ_ff    <= occ_in;
      end
   end

   // storage update: each entry takes its own neighbor on a shift
   always_ff @(posedge clock) begin
      for (int j = 0; j < DEPTH; j++) begin
         if (do_ins) begin
            if (CNT_W'(j) == idx_ff) begin
               val_ff[j] <= v_ff;
               pri_ff[j] <= p_ff;
            end else if ((CNT_W'(j) > idx_ff) && (j > 0)) begin
               val_ff[j] <= val_ff[(j > 0) ? j - 1 : 0];
               pri_ff[j] <= pri_ff[(j > 0) ? j - 1 : 0];
            end
         end else if (do_rem) begin
            if ((CNT_W'(j) >= idx_ff) && (j < DEPTH - 1)) begin
               val_ff[j] <= val_ff[(j < DEPTH - 1) ? j + 1 : j];
               pri_ff[j] <= pri_ff[(j < DEPTH - 1) ? j + 1 : j];
            end
         end
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_position       = pos_ff;
   assign rsp_found_priority = fpri_ff;
   assign rsp_occupancy      = occ_ff;

endmodule : spq_datapath
`default_nettype wire

// ----- hdl/spq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches the top level's channels and the consistency of result items.
// ----------------------------------------------------------------------------
module spq_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_valid,
   input wire                                 req_ready,
   input wire                                 rsp_valid,
   input wire                                 rsp_ready,
   input wire        [spq_pkg::STAT_W-1:0]    rsp_status,
   input wire        [spq_pkg::POS_W-1:0]     rsp_position,
   input wire signed [spq_pkg::IN_PRI_W-1:0]  rsp_found_priority,
   input wire        [spq_pkg::OCC_W-1:0]     rsp_occupancy
);
   import spq_pkg::*;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_position) && $stable(rsp_occupancy)
         && $stable(rsp_found_priority))
      else $error("result item changed while stalled");

   // a rejected insert reports a full queue and empty fields
   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_FULL) |->
         (rsp_position == '0) && (rsp_found_priority == '0)
         && (rsp_occupancy == OCC_W'(DEPTH)))
      else $error("full status with inconsistent fields");

   // a miss carries no position or priority
   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_NOT_FOUND) |->
         (rsp_position == '0) && (rsp_found_priority == '0))
      else $error("not-found status with nonzero fields");

   // no input is taken while a scan is still at work: ready drops after accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in work");

   // no result is pending right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule : spq_checker

bind sorted_priority_queue_top spq_checker u_spq_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_position       (rsp_position),
   .rsp_found_priority (rsp_found_priority),
   .rsp_occupancy      (rsp_occupancy)
);
`default_nettype wire

// ----- bench/sorted_priority_queue_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_tb: self-checking bench for the sorted queue
// A driver sends insert, search and remove items from a queue of pending
// operations. A shadow copy of the sorted list predicts each result item,
// and a monitor compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_tb;
   import spq_pkg::*;

   // func code the block treats as a miss
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam int CLK_HALF     = 10;
   localparam int RANDOM_OPS   = 800;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = DEPTH + 4;
   localparam int POOL_SIZE    = 12;

   // random segment flavors
   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [IN_VAL_W-1:0] value;
      logic [IN_PRI_W-1:0] prio;
   } queue_op_type;

   typedef struct packed {
      logic [STAT_W-1:0]   status;
      logic [POS_W-1:0]    position;
      logic [IN_PRI_W-1:0] found_priority;
      logic [OCC_W-1:0]    occupancy;
   } queue_result_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid         = 1'b0;
   logic                       req_ready;
   logic [FUNC_W-1:0]          req_func          = '0;
   logic signed [IN_VAL_W-1:0] req_item_value    = '0;
   logic signed [IN_PRI_W-1:0] req_item_priority = '0;
   logic                       rsp_valid;
   logic                       rsp_ready         = 1'b0;
   logic [STAT_W-1:0]          rsp_status;
   logic [POS_W-1:0]           rsp_position;
   logic signed [IN_PRI_W-1:0] rsp_found_priority;
   logic [OCC_W-1:0]           rsp_occupancy;

   // shadow copy of the sorted list
   logic [VALUE_WIDTH-1:0]           held_value    [DEPTH];
   logic signed [PRIORITY_WIDTH-1:0] held_priority [DEPTH];
   int                               held_count = 0;

   queue_op_type     pending_ops[$];
   queue_result_type expected_results[$];
   queue_result_type oldest_result;
   logic [IN_VAL_W-1:0] value_pool [POOL_SIZE];

   int total_ops     = 1;
   int ops_accepted  = 0;
   int results_taken = 0;
   int error_count   = 0;
   int stall_cycles  = 0;

   sorted_priority_queue_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_item_value     (req_item_value),
      .req_item_priority  (req_item_priority),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_position       (rsp_position),
      .rsp_found_priority (rsp_found_priority),
      .rsp_occupancy      (rsp_occupancy)
   );

   // clock and one reset pulse
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // apply one operation to the shadow list, return the result it gives
   function automatic queue_result_type apply_queue_op(input queue_op_type op);
      queue_result_type                 res;
      logic [VALUE_WIDTH-1:0]           v;
      logic signed [PRIORITY_WIDTH-1:0] p;
      int                               slot;
      res.status         = STAT_NOT_FOUND;
      res.position       = '0;
      res.found_priority = '0;
      v    = op.value;
      p    = $signed(op.prio);
      slot = -1;
      case (op.func)
         FUNC_INSERT: begin
            if (held_count >= DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               // before the first strictly greater priority, else at the tail
               slot = held_count;
               for (int i = held_count - 1; i >= 0; i--)
                  if (p < held_priority[i]) slot = i;
               for (int i = held_count; i > slot; i--) begin
                  held_value[i]    = held_value[i-1];
                  held_priority[i] = held_priority[i-1];
               end
               held_value[slot]    = v;
               held_priority[slot] = p;
               held_count++;
               res.status   = STAT_OK;
               res.position = slot[POS_W-1:0];
            end
         end
         FUNC_SEARCH, FUNC_REMOVE: begin
            // first match from the head
            for (int i = held_count - 1; i >= 0; i--)
               if (held_value[i] == v) slot = i;
            if (slot >= 0) begin
               res.status         = STAT_OK;
               res.position       = slot[POS_W-1:0];
               res.found_priority = held_priority[slot];
               if (op.func == FUNC_REMOVE) begin
                  for (int i = slot; i + 1 < held_count; i++) begin
                     held_value[i]    = held_value[i+1];
                     held_priority[i] = held_priority[i+1];
                  end
                  held_count--;
               end
            end
         end
         default: ;
      endcase
      res.occupancy = held_count[OCC_W-1:0];
      return res;
   endfunction

   // mostly pooled values so searches and removes hit
   function automatic logic [IN_VAL_W-1:0] pick_value();
      if ($urandom_range(9) < 7) return value_pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom();
   endfunction

   // extremes, a tight cluster for ties, or anything
   function automatic logic [IN_PRI_W-1:0] pick_priority();
      case ($urandom_range(3))
         0:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
         1:       return IN_PRI_W'($urandom_range(6)) - IN_PRI_W'(3);
         default: return IN_PRI_W'($urandom());
      endcase
   endfunction

   task automatic add_op(input logic [FUNC_W-1:0] f, input logic [IN_VAL_W-1:0] v,
                         input logic [IN_PRI_W-1:0] p);
      queue_op_type op;
      op.func  = f;
      op.value = v;
      op.prio  = p;
      pending_ops.push_back(op);
   endtask

   // idle percentages per phase of the run
   function automatic int sender_idle_pct();
      case (ops_accepted * 3 / total_ops)
         0:       return 25;
         1:       return 80;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (results_taken * 3 / total_ops)
         0:       return 80;
         1:       return 25;
         default: return 0;
      endcase
   endfunction

   // stimulus and end of run
   initial begin : stimulus
      int                  mode;
      int                  seg_len;
      int                  roll;
      logic [FUNC_W-1:0]   f;
      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'hffff_ffff;
      value_pool[2] = 32'h7fff_ffff;
      value_pool[3] = 32'h8000_0000;
      for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom();

      // empty queue: misses and the unused code
      add_op(FUNC_SEARCH, 32'h0000_0000, 16'h0000);
      add_op(FUNC_REMOVE, 32'hffff_ffff, 16'hffff);
      add_op(FUNC_UNUSED, 32'h0000_0000, 16'h0000);
      // extremes, a tie and a duplicate value
      add_op(FUNC_INSERT, 32'h7fff_ffff, 16'h7fff);
      add_op(FUNC_INSERT, 32'h8000_0000, 16'h8000);
      add_op(FUNC_INSERT, 32'h0000_0000, 16'h0000);
      add_op(FUNC_INSERT, 32'hffff_ffff, 16'h0000);
      add_op(FUNC_INSERT, 32'h0000_0000, 16'h0005);
      add_op(FUNC_SEARCH, 32'h0000_0000, 16'h1234);
      add_op(FUNC_SEARCH, 32'hffff_ffff, 16'h0000);
      add_op(FUNC_UNUSED, 32'h0000_0000, 16'h7fff);
      // remove from the middle, the tail, then down to empty
      add_op(FUNC_REMOVE, 32'h0000_0000, 16'h0000);
      add_op(FUNC_REMOVE, 32'h7fff_ffff, 16'h0000);
      add_op(FUNC_REMOVE, 32'h8000_0000, 16'h0000);
      add_op(FUNC_REMOVE, 32'h0000_0000, 16'h0000);
      add_op(FUNC_REMOVE, 32'hffff_ffff, 16'h0000);

      // fill to capacity and one rejected insert
      repeat (DEPTH + 1) add_op(FUNC_INSERT, pick_value(), pick_priority());

      // random segments that push the queue toward full or empty, or mix the operations
      while (pending_ops.size() < RANDOM_OPS + 16) begin
         mode    = $urandom_range(MODE_MIXED);
         seg_len = $urandom_range(10, 40);
         repeat (seg_len) begin
            roll = $urandom_range(99);
            case (mode)
               MODE_FILL:  f = (roll < 80) ? FUNC_INSERT : (roll < 90) ? FUNC_SEARCH :
                               (roll < 97) ? FUNC_REMOVE : FUNC_UNUSED;
               MODE_DRAIN: f = (roll < 15) ? FUNC_INSERT : (roll < 35) ? FUNC_SEARCH :
                               (roll < 95) ? FUNC_REMOVE : FUNC_UNUSED;
               default:    f = (roll < 40) ? FUNC_INSERT : (roll < 65) ? FUNC_SEARCH :
                               (roll < 95) ? FUNC_REMOVE : FUNC_UNUSED;
            endcase
            add_op(f, pick_value(), pick_priority());
         end
      end
      total_ops = pending_ops.size();

      // wait until every item is sent and answered
      do @(negedge clock);
      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // driver: predict on acceptance, then offer the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(apply_queue_op(
               queue_op_type'({req_func, req_item_value, req_item_priority})));
            ops_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
               req_func          <= pending_ops[0].func;
               req_item_value    <= pending_ops[0].value;
               req_item_priority <= pending_ops[0].prio;
               req_valid         <= 1'b1;
               void'(pending_ops.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result item against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_taken++;
            if (expected_results.size() == 0) begin
               $error("result item with no request outstanding");
               error_count++;
            end else begin
               oldest_result = expected_results.pop_front();
               if (rsp_status !== oldest_result.status) begin
                  $error("status: expected %0d, got %0d", oldest_result.status, rsp_status);
                  error_count++;
               end
               if (rsp_position !== oldest_result.position) begin
                  $error("position: expected %0d, got %0d",
                         oldest_result.position, rsp_position);
                  error_count++;
               end
               if (rsp_found_priority !== oldest_result.found_priority) begin
                  $error("found_priority: expected %0d, got %0d",
                         $signed(oldest_result.found_priority), rsp_found_priority);
                  error_count++;
               end
               if (rsp_occupancy !== oldest_result.occupancy) begin
                  $error("occupancy: expected %0d, got %0d",
                         oldest_result.occupancy, rsp_occupancy);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   // watchdog: too long with nothing accepted on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
